// ----- design/psmvc_pkg.sv -----
// ----------------------------------------------------------------------------
// psmvc_pkg
// shared constants, types and helpers of the pcm stream mixer
// ----------------------------------------------------------------------------
package psmvc_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int VOL_W        = 7;
	localparam int CFG_IDX_W    = 4;
	localparam int PIPE_STAGES  = 6;

	// per-stream scaling widths
	localparam int LANE_PROD_W  = 23;   // sample * volume, signed
	localparam int LANE_MAG_W   = 22;   // magnitude of the above
	localparam int LANE_W       = 17;   // scaled sample, signed

	// divide by 100: floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for x < 2**30
	localparam int RECIP_W      = 26;
	localparam int RECIP_SHIFT  = 32;
	localparam logic [RECIP_W-1:0] RECIP = 26'd42949673;

	localparam logic [VOL_W-1:0]    VOL_FULL   = 7'd100;
	localparam logic [SAMPLE_W-2:0] CLIP_LIMIT = 15'h7fff;

	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME = 4'd0;

	typedef struct packed {
		logic [PIPE_STAGES-1:0] load;   // stage k register captures
	} pipe_ctrl_t;

	function automatic logic [VOL_W-1:0] clamp_vol(input logic [VOL_W-1:0] v);
		clamp_vol = (v > VOL_FULL) ? VOL_FULL : v;
	endfunction

endpackage

// ----- design/pcm_stream_mixer_volume_clip_top.sv -----
// ----------------------------------------------------------------------------
// pcm_stream_mixer_volume_clip_top
// mixes several pcm streams with per-stream and master volume and clipping
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: sample_0..sample_n-1, stream_mask
// m_        out  m_tvalid/m_tready  m_tdata: mixed_sample
// cfg_      in   cfg_we             cfg_index, cfg_data (volume registers)
//
// six register stages: lane multiply, divide by 100, sum + negate,
// master multiply, divide by 100, clip into the output register.
// one item per cycle while m_tready holds; each accepted item passes
// through the stages in order, and m_tvalid rises when it reaches the last.
// each stage loads when it is empty or its successor moves, so bubbles
// are squeezed out under stall and nothing is lost or repeated.
// arst_n clears the valid bits and sets all volumes to 100.
// ----------------------------------------------------------------------------
module pcm_stream_mixer_volume_clip_top #(
	parameter int STREAM_COUNT = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// sample_0 .. sample_n-1 (16 bits each), stream_mask, zero pad
	input  logic [((psmvc_pkg::SAMPLE_W+1)*STREAM_COUNT+7)/8*8-1:0] s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// mixed_sample
	output logic [psmvc_pkg::SAMPLE_W-1:0]        m_tdata,
	input  logic                                  cfg_we,
	input  logic [psmvc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [psmvc_pkg::VOL_W-1:0]           cfg_data
);

	localparam int NS = psmvc_pkg::PIPE_STAGES;
	localparam int SW = psmvc_pkg::SAMPLE_W;

	logic [psmvc_pkg::VOL_W-1:0]          master_vol_q;
	logic [psmvc_pkg::VOL_W-1:0]          stream_vol_q [STREAM_COUNT];
	logic [NS-1:0]                        vld_q;
	psmvc_pkg::pipe_ctrl_t                ctrl;
	logic signed [psmvc_pkg::LANE_W-1:0]  scaled [STREAM_COUNT];
	logic [STREAM_COUNT-1:0]              mask;
	logic signed [SW-1:0]                 mixed_sample;

	// config registers, values above 100 stored as 100
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_vol_q <= psmvc_pkg::VOL_FULL;
			for (int k = 0; k < STREAM_COUNT; k++) begin
				stream_vol_q[k] <= psmvc_pkg::VOL_FULL;
			end
		end else if (cfg_we) begin
			if (cfg_index == psmvc_pkg::CFG_MASTER_VOLUME) begin
				master_vol_q <= psmvc_pkg::clamp_vol(cfg_data);
			end
			for (int k = 0; k < STREAM_COUNT; k++) begin
				if (cfg_index == psmvc_pkg::CFG_IDX_W'(k + 1)) begin
					stream_vol_q[k] <= psmvc_pkg::clamp_vol(cfg_data);
				end
			end
		end
	end

	// stage load chain from the output back to the input
	always_comb begin
		ctrl.load[NS-1] = !vld_q[NS-1] || m_tready;
		for (int i = NS - 2; i >= 0; i--) begin
			ctrl.load[i] = !vld_q[i] || ctrl.load[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctrl.load[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NS; i++) begin
				if (ctrl.load[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign mask = s_tdata[SW*STREAM_COUNT +: STREAM_COUNT];

	for (genvar k = 0; k < STREAM_COUNT; k++) begin : g_lane
		psmvc_lane u_lane (
			.clk    (clk),
			.ctrl   (ctrl),
			.sample ($signed(s_tdata[SW*k +: SW])),
			.enable (mask[k]),
			.volume (stream_vol_q[k]),
			.scaled (scaled[k])
		);
	end

	psmvc_mix #(
		.STREAM_COUNT (STREAM_COUNT)
	) u_mix (
		.clk           (clk),
		.ctrl          (ctrl),
		.scaled        (scaled),
		.master_volume (master_vol_q),
		.mixed_sample  (mixed_sample)
	);

	assign s_tready = ctrl.load[0];
	assign m_tvalid = vld_q[NS-1];
	assign m_tdata  = mixed_sample;

	// clipping keeps the most negative code out of the output
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != {1'b1, {(SW-1){1'b0}}})
		else $error("output holds the most negative code");

	// an accepted item lands in the first stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted item not captured");

	// a stalled result is neither dropped nor changed
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result lost");

	// the input side only stalls when every stage is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_q == {NS{1'b1}} && !m_tready)
		else $error("input stalled with a free stage");

endmodule

// ----- design/psmvc_lane.sv -----
// ----------------------------------------------------------------------------
// psmvc_lane
// one stream: sample times stream volume, then divide by 100 toward zero
// ----------------------------------------------------------------------------
module psmvc_lane (
	input  logic                                  clk,
	input  psmvc_pkg::pipe_ctrl_t                 ctrl,
	input  logic signed [psmvc_pkg::SAMPLE_W-1:0] sample,
	input  logic                                  enable,
	input  logic        [psmvc_pkg::VOL_W-1:0]    volume,
	output logic signed [psmvc_pkg::LANE_W-1:0]   scaled
);

	localparam int PW = psmvc_pkg::LANE_MAG_W + psmvc_pkg::RECIP_W;
	localparam int QW = PW - psmvc_pkg::RECIP_SHIFT;

	logic signed [psmvc_pkg::SAMPLE_W+psmvc_pkg::VOL_W:0] prod_c;
	logic signed [psmvc_pkg::LANE_PROD_W-1:0]             prod_s1;
	logic signed [psmvc_pkg::LANE_PROD_W-1:0]             neg_prod_c;
	logic        [psmvc_pkg::LANE_MAG_W-1:0]              mag_c;
	logic        [PW-1:0]                                 recip_c;
	logic        [QW-1:0]                                 quo_s2;
	logic                                                 neg_s2;
	logic signed [psmvc_pkg::LANE_W-1:0]                  quo_ext;

	always_comb begin
		prod_c     = (psmvc_pkg::SAMPLE_W+psmvc_pkg::VOL_W+1)'(sample)
		           * $signed({1'b0, volume});
		neg_prod_c = -prod_s1;
		mag_c      = prod_s1[psmvc_pkg::LANE_PROD_W-1]
		           ? neg_prod_c[psmvc_pkg::LANE_MAG_W-1:0]
		           : prod_s1[psmvc_pkg::LANE_MAG_W-1:0];
		recip_c    = PW'(mag_c) * PW'(psmvc_pkg::RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			// disabled streams contribute nothing
			prod_s1 <= enable ? prod_c[psmvc_pkg::LANE_PROD_W-1:0] : '0;
		end
		if (ctrl.load[1]) begin
			quo_s2 <= recip_c[PW-1:psmvc_pkg::RECIP_SHIFT];
			neg_s2 <= prod_s1[psmvc_pkg::LANE_PROD_W-1];
		end
	end

	assign quo_ext = $signed({1'b0, quo_s2});
	assign scaled  = neg_s2 ? -quo_ext : quo_ext;

endmodule

// ----- design/psmvc_mix.sv -----
// ----------------------------------------------------------------------------
// psmvc_mix
// sums the scaled streams, applies master volume, divides by 100, saturates
// ----------------------------------------------------------------------------
module psmvc_mix #(
	parameter int STREAM_COUNT = 4
) (
	input  logic                                  clk,
	input  psmvc_pkg::pipe_ctrl_t                 ctrl,
	input  logic signed [psmvc_pkg::LANE_W-1:0]   scaled [STREAM_COUNT],
	input  logic        [psmvc_pkg::VOL_W-1:0]    master_volume,
	output logic signed [psmvc_pkg::SAMPLE_W-1:0] mixed_sample
);

	localparam int SUM_W = psmvc_pkg::LANE_W + $clog2(STREAM_COUNT);
	localparam int MST_W = SUM_W + psmvc_pkg::VOL_W;
	localparam int MAG_W = MST_W - 1;
	localparam int PW    = MAG_W + psmvc_pkg::RECIP_W;
	localparam int QW    = PW - psmvc_pkg::RECIP_SHIFT;

	logic signed [SUM_W-1:0]              sum_c;
	logic signed [SUM_W-1:0]              sum_s3;
	logic signed [MST_W-1:0]              mst_c;
	logic signed [MST_W-1:0]              mst_s4;
	logic signed [MST_W-1:0]              neg_mst_c;
	logic        [MAG_W-1:0]              mag_c;
	logic        [PW-1:0]                 recip_c;
	logic        [QW-1:0]                 quo_s5;
	logic                                 neg_s5;
	logic        [psmvc_pkg::SAMPLE_W-2:0] sat_c;
	logic signed [psmvc_pkg::SAMPLE_W-1:0] sat_ext;
	logic signed [psmvc_pkg::SAMPLE_W-1:0] mixed_s6;

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < STREAM_COUNT; k++) begin
			sum_c = sum_c + SUM_W'(scaled[k]);
		end
		mst_c     = MST_W'(sum_s3) * MST_W'($signed({1'b0, master_volume}));
		neg_mst_c = -mst_s4;
		mag_c     = mst_s4[MST_W-1] ? neg_mst_c[MAG_W-1:0] : mst_s4[MAG_W-1:0];
		recip_c   = PW'(mag_c) * PW'(psmvc_pkg::RECIP);
		// clip the magnitude, so the most negative code never appears
		sat_c     = (quo_s5 > QW'(psmvc_pkg::CLIP_LIMIT))
		          ? psmvc_pkg::CLIP_LIMIT
		          : quo_s5[psmvc_pkg::SAMPLE_W-2:0];
		sat_ext   = $signed({1'b0, sat_c});
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			sum_s3 <= sum_c;
		end
		if (ctrl.load[3]) begin
			mst_s4 <= mst_c;
		end
		if (ctrl.load[4]) begin
			quo_s5 <= recip_c[PW-1:psmvc_pkg::RECIP_SHIFT];
			neg_s5 <= mst_s4[MST_W-1];
		end
		if (ctrl.load[5]) begin
			mixed_s6 <= neg_s5 ? -sat_ext : sat_ext;
		end
	end

	assign mixed_sample = mixed_s6;

endmodule
